>>> rtl/core/oled_fb_pkg.sv
// shared types, command codes and panel byte constants for the oled frame buffer flusher
package oled_fb_pkg;

  typedef enum logic [2:0] {
    OP_DRAW    = 3'd0,
    OP_FLUSH   = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_DISP_ON = 3'd3,
    OP_DISP_OFF = 3'd4,
    OP_TICK    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_IDLE    = 2'd0,
    KIND_REFRESH = 2'd1,
    KIND_ON      = 2'd2,
    KIND_OFF     = 2'd3
  } kind_e;

  localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] CMD_COL_LO      = 8'h00;
  localparam logic [7:0] CMD_COL_HI      = 8'h10;
  localparam logic [7:0] CMD_CHARGE_PUMP = 8'h8D;
  localparam logic [7:0] CMD_PUMP_ON     = 8'h14;
  localparam logic [7:0] CMD_PUMP_OFF    = 8'h10;
  localparam logic [7:0] CMD_DISP_ON     = 8'hAF;
  localparam logic [7:0] CMD_DISP_OFF    = 8'hAE;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] column;
    logic [5:0] row;
    logic       pixel_on;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_data;
    logic       end_of_sequence;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  seq_start;
    kind_e seq_kind;
    logic  rd_draw;
    logic  wr_draw;
    logic  clr_wr;
    logic  emit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seq_idle;
    logic clr_last;
  } ctl_sts_t;

  // three-byte display on/off command lists
  function automatic logic [7:0] onoff_byte(input kind_e kind, input logic [1:0] idx);
    logic [7:0] b;
    b = CMD_CHARGE_PUMP;
    case (idx)
      2'd0: b = CMD_CHARGE_PUMP;
      2'd1: b = (kind == KIND_ON) ? CMD_PUMP_ON : CMD_PUMP_OFF;
      default: b = (kind == KIND_ON) ? CMD_DISP_ON : CMD_DISP_OFF;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/oled_fb_ctrl.sv
// controller state machine: item decode, clear sweep, draw read-modify-write, tick
module oled_fb_ctrl import oled_fb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_op,
  input  ctl_sts_t   sts,
  output ctl_cmd_t   cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLEAR  = 5'b00010,
    S_DRW_RD = 5'b00100,
    S_DRW_WR = 5'b01000,
    S_TICK   = 5'b10000
  } state_e;

  state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;   // memory is swept to zero after reset
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.seq_kind  = KIND_IDLE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (op_e'(in_op))
            OP_DRAW: state_nxt = S_DRW_RD;
            OP_FLUSH: begin
              cmd.seq_start = sts.seq_idle;
              cmd.seq_kind  = KIND_REFRESH;
            end
            OP_CLEAR: begin
              if (sts.seq_idle) begin
                cmd.seq_start = 1'b1;
                cmd.seq_kind  = KIND_REFRESH;
                state_nxt     = S_CLEAR;
              end
            end
            OP_DISP_ON: begin
              cmd.seq_start = sts.seq_idle;
              cmd.seq_kind  = KIND_ON;
            end
            OP_DISP_OFF: begin
              cmd.seq_start = sts.seq_idle;
              cmd.seq_kind  = KIND_OFF;
            end
            OP_TICK: state_nxt = S_TICK;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DRW_RD: begin
        cmd.rd_draw = 1'b1;
        state_nxt   = S_DRW_WR;
      end
      S_DRW_WR: begin
        cmd.rd_draw = 1'b1;
        cmd.wr_draw = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_TICK: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/oled_fb_dp.sv
// datapath: frame memory, sequence counters and registered result
module oled_fb_dp import oled_fb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int COLW  = $clog2(COLUMNS);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = COLW + PGW;
  localparam int DEPTH = 2 ** AW;
  localparam int POSW  = $clog2(COLUMNS + 3);

  logic [7:0]      mem [DEPTH];
  logic [7:0]      rd_data_r;
  in_item_t        item_r;
  kind_e           kind_r, kind_nxt;
  logic [PGW-1:0]  page_r, page_nxt;
  logic [POSW-1:0] pos_r, pos_nxt;
  logic [AW-1:0]   clr_addr_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  // draw address and mask
  logic [2:0]      grp;
  logic            in_range;
  logic [COLW-1:0] draw_col;
  logic [PGW-1:0]  draw_page;
  logic [AW-1:0]   draw_addr;
  logic [7:0]      mask;
  logic [7:0]      draw_byte;

  // refresh address
  logic [COLW-1:0] seq_col;
  logic [AW-1:0]   seq_addr;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [7:0]      wr_data;
  logic            wr_en;
  logic [1:0]      onoff_idx;

  assign grp       = item_r.row[5:3];
  assign in_range  = (32'(item_r.column) < COLUMNS) && (32'(grp) < PAGES);
  assign draw_col  = COLW'(item_r.column);
  assign draw_page = PGW'(PAGES - 1 - 32'(grp));
  assign draw_addr = {draw_col, draw_page};
  assign mask      = 8'h80 >> item_r.row[2:0];
  assign draw_byte = item_r.pixel_on ? (rd_data_r | mask) : (rd_data_r & ~mask);

  assign seq_col  = COLW'(pos_r - POSW'(3));
  assign seq_addr = {seq_col, page_r};

  assign rd_addr = cmd.rd_draw ? draw_addr : seq_addr;
  assign wr_en   = cmd.clr_wr || (cmd.wr_draw && in_range);
  assign wr_addr = cmd.clr_wr ? clr_addr_r : draw_addr;
  assign wr_data = cmd.clr_wr ? 8'h00 : draw_byte;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign sts.clr_last = (clr_addr_r == {AW{1'b1}});
  assign sts.seq_idle = (kind_r == KIND_IDLE);

  assign onoff_idx = (pos_r < POSW'(3)) ? pos_r[1:0] : 2'd2;

  always_comb begin
    kind_nxt      = kind_r;
    page_nxt      = page_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (cmd.seq_start) begin
      kind_nxt = cmd.seq_kind;
      page_nxt = '0;
      pos_nxt  = '0;
    end else if (cmd.emit) begin
      case (kind_r)
        KIND_ON, KIND_OFF: begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.byte_value      = onoff_byte(kind_r, onoff_idx);
          out_item_nxt.is_data         = 1'b0;
          out_item_nxt.end_of_sequence = (onoff_idx == 2'd2);
          if (onoff_idx == 2'd2) begin
            kind_nxt = KIND_IDLE;
            page_nxt = '0;
            pos_nxt  = '0;
          end else begin
            pos_nxt = POSW'(onoff_idx) + POSW'(1);
          end
        end
        KIND_REFRESH: begin
          out_valid_nxt                = 1'b1;
          out_item_nxt.end_of_sequence = 1'b0;
          if (pos_r < POSW'(3)) begin
            // page address, low and high column start
            out_item_nxt.is_data = 1'b0;
            case (pos_r[1:0])
              2'd0:    out_item_nxt.byte_value = CMD_PAGE_BASE + 8'(page_r);
              2'd1:    out_item_nxt.byte_value = CMD_COL_LO;
              default: out_item_nxt.byte_value = CMD_COL_HI;
            endcase
            pos_nxt = pos_r + POSW'(1);
          end else begin
            out_item_nxt.is_data    = 1'b1;
            out_item_nxt.byte_value = rd_data_r;
            if (seq_col == COLW'(COLUMNS - 1)) begin
              if (page_r == PGW'(PAGES - 1)) begin
                out_item_nxt.end_of_sequence = 1'b1;
                kind_nxt = KIND_IDLE;
                page_nxt = '0;
                pos_nxt  = '0;
              end else begin
                page_nxt = page_r + PGW'(1);
                pos_nxt  = '0;
              end
            end else begin
              pos_nxt = pos_r + POSW'(1);
            end
          end
        end
        default: out_valid_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_IDLE;
      page_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      kind_r      <= kind_nxt;
      page_r      <= page_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/core/oled_page_framebuffer_flusher.sv
// top level: page-organised oled frame buffer with panel byte sequencer
//
// input channel: an item (in_item) is taken at a clock edge where start is
// high and busy is low. operations are draw, flush, clear, display on,
// display off and tick; flush, clear and on/off are dropped while a
// sequence is still pending.
// result channel: a tick that has a byte to send raises out_valid for one
// cycle with out_item (byte, command/data flag, end-of-sequence flag).
// the receiver cannot stall; each result is taken in the cycle it shows.
// sequencing: flush, display on/off, dropped requests and unused codes
// leave busy low; a tick goes through the registered frame memory read,
// then the result register, and its result shows in the first cycle with
// busy low again; a draw steps through read, modify and write states;
// a clear that is taken keeps busy high while the memory is zeroed one
// byte a cycle.
// reset: synchronous active low; afterwards the block runs the same
// zeroing sweep with busy high before it takes its first item.
module oled_page_framebuffer_flusher import oled_fb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  oled_fb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_item.operation),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  oled_fb_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
